>>> rtl/radiogatun32_prng_assert.svh
// Assertion macros for the generator; clocked on clock, disabled in reset.
`ifndef RADIOGATUN32_PRNG_ASSERT_SVH
`define RADIOGATUN32_PRNG_ASSERT_SVH
`ifndef SYNTHESIS
`define RG32_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define RG32_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RG32_ASSERT_IMP(label, ante, cons, msg)
`define RG32_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/rg32_pkg.sv
package rg32_pkg;

   localparam int WORD_W      = 32;
   localparam int MILL_N      = 19;
   localparam int BELT_ROW    = 13;
   localparam int BELT_N      = 39;
   localparam int SEED_ROUNDS = 17;
   localparam int ROUND_CNT_W = $clog2(SEED_ROUNDS);

   typedef enum logic {
      CMD_RESEED = 1'b0,
      CMD_DRAW   = 1'b1
   } rg32_op_type;

   typedef struct packed {
      logic load;      // clear state and inject the seed
      logic step;      // run one belt-mill round
      logic take_m1;   // capture mill[1] after this round
      logic take_m2;   // capture current mill[2]
   } rg32_cmd_type;

endpackage

>>> rtl/rg32_req_if.sv
interface rg32_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] seed;

   modport source (output valid, output cmd, output seed, input ready);
   modport sink   (input valid, input cmd, input seed, output ready);
endinterface

>>> rtl/rg32_rsp_if.sv
interface rg32_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

>>> rtl/rg32_datapath.sv
module rg32_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  rg32_pkg::rg32_cmd_type   cmd,
   input  logic [31:0]              seed,
   output logic [31:0]              word
);
   import rg32_pkg::*;

   logic [WORD_W-1:0] mill_ff  [MILL_N];
   logic [WORD_W-1:0] mill_in  [MILL_N];
   logic [WORD_W-1:0] mill_nxt [MILL_N];
   logic [WORD_W-1:0] belt_ff  [BELT_N];
   logic [WORD_W-1:0] belt_in  [BELT_N];
   logic [WORD_W-1:0] belt_nxt [BELT_N];
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   // One full belt-mill round; every rotation and index is fixed wiring.
   always_comb begin : round_logic
      logic [WORD_W-1:0]   t  [MILL_N];
      logic [WORD_W-1:0]   bf [BELT_N];
      logic [WORD_W-1:0]   x;
      logic [2*WORD_W-1:0] rr;
      int                  rot;
      int                  k;
      rot = 0;
      for (int i = 0; i < BELT_N; i++) bf[i] = belt_ff[i];
      for (int i = 0; i < 12; i++)
         bf[i + (i % 3) * BELT_ROW] = bf[i + (i % 3) * BELT_ROW] ^ mill_ff[i + 1];
      for (int i = 0; i < MILL_N; i++) begin
         rot  = (rot + i) & 31;
         k    = (i * 7) % MILL_N;
         x    = mill_ff[k] ^ (mill_ff[(k + 1) % MILL_N] | ~mill_ff[(k + 2) % MILL_N]);
         rr   = {x, x} >> rot;
         t[i] = rr[WORD_W-1:0];
      end
      for (int i = 0; i < MILL_N; i++)
         mill_nxt[i] = t[i] ^ t[(i + 1) % MILL_N] ^ t[(i + 4) % MILL_N];
      mill_nxt[0] = mill_nxt[0] ^ 32'd1;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < BELT_ROW; c++)
            belt_nxt[r * BELT_ROW + c] = bf[r * BELT_ROW + ((c == 0) ? BELT_ROW - 1 : c - 1)];
      for (int r = 0; r < 3; r++)
         mill_nxt[BELT_ROW + r] = mill_nxt[BELT_ROW + r] ^ belt_nxt[r * BELT_ROW];
   end

   always_comb begin
      for (int i = 0; i < MILL_N; i++) mill_in[i] = mill_ff[i];
      for (int i = 0; i < BELT_N; i++) belt_in[i] = belt_ff[i];
      if (cmd.load) begin
         for (int i = 0; i < MILL_N; i++) mill_in[i] = '0;
         for (int i = 0; i < BELT_N; i++) belt_in[i] = '0;
         mill_in[16]       = seed;
         mill_in[17]       = 32'd1;
         belt_in[0]        = seed;
         belt_in[BELT_ROW] = 32'd1;
      end else if (cmd.step) begin
         for (int i = 0; i < MILL_N; i++) mill_in[i] = mill_nxt[i];
         for (int i = 0; i < BELT_N; i++) belt_in[i] = belt_nxt[i];
      end
   end

   always_comb begin
      word_in = word_ff;
      if (cmd.take_m1) word_in = mill_nxt[1];
      else if (cmd.take_m2) word_in = mill_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MILL_N; i++) mill_ff[i] <= '0;
         for (int i = 0; i < BELT_N; i++) belt_ff[i] <= '0;
      end else begin
         for (int i = 0; i < MILL_N; i++) mill_ff[i] <= mill_in[i];
         for (int i = 0; i < BELT_N; i++) belt_ff[i] <= belt_in[i];
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

>>> rtl/rg32_controller.sv
`include "radiogatun32_prng_assert.svh"
module rg32_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rg32_pkg::rg32_cmd_type   cmd
);
   import rg32_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SEEDING
   } state_type;

   state_type              state_ff, state_in;
   logic [ROUND_CNT_W-1:0] count_ff, count_in;
   logic                   round_due_ff, round_due_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   is_draw;
   logic                   seed_last;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_draw   = (rg32_op_type'(req_cmd) == CMD_DRAW);
   assign seed_last = (state_ff == ST_SEEDING) && (count_ff == ROUND_CNT_W'(SEED_ROUNDS - 1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      round_due_in = round_due_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_draw) begin
                  cmd.step     = round_due_ff;
                  cmd.take_m1  = round_due_ff;
                  cmd.take_m2  = !round_due_ff;
                  round_due_in = !round_due_ff;
                  rsp_valid_in = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  count_in = '0;
                  state_in = ST_SEEDING;
               end
            end
         end
         ST_SEEDING: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (seed_last) begin
               count_in     = '0;
               round_due_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         round_due_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         round_due_ff <= round_due_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RG32_ASSERT_IMP(a_no_accept_seeding, state_ff == ST_SEEDING, !req_ready, "ready while seeding")
   `RG32_ASSERT_NXT(a_reseed_enters, accept && !is_draw, state_ff == ST_SEEDING, "reseed lost")
   `RG32_ASSERT_NXT(a_draw_gives_word, accept && is_draw, rsp_valid_ff, "draw gave no word")
   `RG32_ASSERT_IMP(a_count_range, 1'b1, count_ff < ROUND_CNT_W'(SEED_ROUNDS), "count overrun")
   `RG32_ASSERT_NXT(a_seed_done_due, seed_last, round_due_ff, "round not due after reseed")

endmodule

>>> rtl/radiogatun32_prng.sv
// RadioGatun[32] word generator.
// Draw: word registered, valid the cycle after acceptance; one draw per cycle
//    when words are taken; a full belt-mill round runs with each mill[1] word.
// Reseed: load on acceptance, then SEED_ROUNDS rounds run with ready low.
// Reset (synchronous): mill and belt cleared, a round due, no word pending.
module radiogatun32_prng (
   input  logic        clock,
   input  logic        reset,
   rg32_req_if.sink    req_chan,
   rg32_rsp_if.source  rsp_chan
);
   import rg32_pkg::*;

   rg32_cmd_type cmd;
   logic         req_ready;
   logic         rsp_valid;
   logic [31:0]  rsp_word;

   rg32_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .req_cmd   (req_chan.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   rg32_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .seed  (req_chan.seed),
      .word  (rsp_word)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.word  = rsp_word;

endmodule

>>> dv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rg32_pkg::*;

   typedef struct packed {
      rg32_op_type op;
      logic [31:0] seed;
      logic        known;   // expected word typed in below
      logic [31:0] word;
   } stim_row_type;

   localparam int N_DIRECTED  = 21;
   localparam int N_RANDOM    = 830;
   localparam int IDLE_PCT    = 26;
   localparam int DRAIN_LIMIT = 5000;

   // Round on the all-zero state leaves every mill word at all ones but word 0.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{CMD_DRAW,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
      '{CMD_DRAW,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_RESEED, 32'h0000_0000, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h1234_5678, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_RESEED, 32'h8000_0001, 1'b0, 32'h0},
      '{CMD_RESEED, 32'h0000_0001, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0},
      '{CMD_RESEED, 32'h7FFF_FFFE, 1'b0, 32'h0},
      '{CMD_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0},
      '{CMD_RESEED, 32'hA5A5_A5A5, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h5A5A_5A5A, 1'b0, 32'h0},
      '{CMD_DRAW,   32'h0000_0000, 1'b0, 32'h0}
   };

   logic clock;
   logic reset;

   rg32_req_if req_chan();
   rg32_rsp_if rsp_chan();

   radiogatun32_prng u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // generator state as predicted
   logic [31:0] mill [MILL_N];
   logic [31:0] belt [BELT_N];
   bit          round_pending;

   logic [31:0] expected_words [$];
   int          mismatches;
   bit          steady_run;
   logic        item_known;
   logic [31:0] item_known_word;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void spin_round();
      logic [31:0] t  [MILL_N];
      logic [31:0] nb [BELT_N];
      logic [31:0] x;
      logic [63:0] rr;
      int          rot;
      int          k;
      int          src;
      rot = 0;
      for (int i = 0; i < 12; i++)
         belt[i + (i % 3) * BELT_ROW] ^= mill[i + 1];
      for (int i = 0; i < MILL_N; i++) begin
         k   = i * 7;
         rot = (rot + i) % 32;
         x   = mill[k % MILL_N] ^ (mill[(k + 1) % MILL_N] | ~mill[(k + 2) % MILL_N]);
         rr  = {x, x} >> rot;
         t[i] = rr[31:0];
      end
      for (int i = 0; i < MILL_N; i++)
         mill[i] = t[i] ^ t[(i + 1) % MILL_N] ^ t[(i + 4) % MILL_N];
      mill[0] ^= 32'd1;
      // each belt row turns by one place
      for (int i = 0; i < BELT_N; i++) begin
         src   = (i % BELT_ROW == 0) ? BELT_ROW - 1 : (i % BELT_ROW) - 1;
         nb[i] = belt[(i / BELT_ROW) * BELT_ROW + src];
      end
      for (int i = 0; i < BELT_N; i++)
         belt[i] = nb[i];
      for (int i = 0; i < 3; i++)
         mill[BELT_ROW + i] ^= belt[i * BELT_ROW];
   endfunction

   function automatic void clear_generator();
      for (int i = 0; i < MILL_N; i++)
         mill[i] = '0;
      for (int i = 0; i < BELT_N; i++)
         belt[i] = '0;
      round_pending = 1'b1;
   endfunction

   function automatic void next_word(input rg32_op_type op, input logic [31:0] seed,
                                     output bit gives, output logic [31:0] word);
      gives = 1'b0;
      word  = '0;
      if (op == CMD_RESEED) begin
         clear_generator();
         belt[0]        = seed;
         mill[16]       = seed;
         belt[BELT_ROW] = 32'd1;
         mill[17]       = 32'd1;
         for (int i = 0; i < SEED_ROUNDS; i++)
            spin_round();
         round_pending = 1'b1;
      end else if (round_pending) begin
         spin_round();
         round_pending = 1'b0;
         gives = 1'b1;
         word  = mill[1];
      end else begin
         round_pending = 1'b1;
         gives = 1'b1;
         word  = mill[2];
      end
   endfunction

   // push expectations first so the check never depends on the result latency
   always @(posedge clock) begin : monitor
      bit          gives;
      logic [31:0] word;
      logic [31:0] want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            next_word(rg32_op_type'(req_chan.cmd), req_chan.seed, gives, word);
            if (gives)
               expected_words.push_back(item_known ? item_known_word : word);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp_chan.word);
            end else begin
               want = expected_words.pop_front();
               if (rsp_chan.word !== want) begin
                  mismatches++;
                  $display("%0t: word mismatch, expected %h, actual %h",
                           $time, want, rsp_chan.word);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic send_item(input rg32_op_type op, input logic [31:0] seed,
                            input logic known, input logic [31:0] known_word);
      @(negedge clock);
      while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.cmd    <= op;
      req_chan.seed   <= seed;
      item_known      <= known;
      item_known_word <= known_word;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int          waited;
      rg32_op_type op;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.cmd    = CMD_RESEED;
      req_chan.seed   = '0;
      item_known      = 1'b0;
      item_known_word = '0;
      steady_run      = 1'b0;
      mismatches      = 0;
      clear_generator();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].seed,
                   directed_rows[i].known, directed_rows[i].word);

      for (int n = 0; n < N_RANDOM; n++) begin
         steady_run = (n >= 300 && n < 450);
         if (n == 600) begin
            // hold off until every word has come back
            @(negedge clock);
            req_chan.valid <= 1'b0;
            while (expected_words.size() != 0)
               @(posedge clock);
         end
         op = ($urandom_range(99) < 10) ? CMD_RESEED : CMD_DRAW;
         send_item(op, $urandom, 1'b0, '0);
      end
      steady_run = 1'b0;

      @(negedge clock);
      req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // a trailing reseed keeps the block busy for its seeding rounds
      repeat (SEED_ROUNDS + 8) @(posedge clock);

      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (expected_words.size() != 0)
            $display("%0t: %0d expected words never arrived, first %h",
                     $time, expected_words.size(), expected_words[0]);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
